[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (con)) \
    else $error("assertion failed");

`endif

[rtl/fvhc_pkg.sv]
`timescale 1ns / 1ps

package fvhc_pkg;

  localparam logic [7:0] JumpShort = 8'hEB;
  localparam logic [7:0] JumpNear  = 8'hE9;

  localparam logic [31:0] SmallLimit  = 32'd4085;
  localparam logic [31:0] MediumLimit = 32'd65525;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StFat12   = 2'd2;

  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindFat16   = 2'd1;
  localparam logic [1:0] KindFat32   = 2'd2;

  // One classified header as it travels from the front to the back.
  typedef struct packed {
    logic        valid;
    logic [6:0]  sec_units;
    logic [12:0] rds_num;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  copies;
    logic [31:0] tsize;
    logic [31:0] total;
  } job_t;

endpackage

[rtl/fvhc_front.sv]
`timescale 1ns / 1ps

module fvhc_front (
  input  logic [7:0]     jump_byte_i,
  input  logic [15:0]    sector_bytes_i,
  input  logic [7:0]     cluster_sectors_i,
  input  logic [15:0]    reserved_count_i,
  input  logic [7:0]     table_copies_i,
  input  logic [15:0]    root_entries_i,
  input  logic [15:0]    total_small_i,
  input  logic [15:0]    table_sectors_small_i,
  input  logic [31:0]    total_large_i,
  input  logic [31:0]    table_sectors_large_i,
  output fvhc_pkg::job_t job_o
);
  import fvhc_pkg::*;

  logic        jump_ok;
  logic        bps_ok;
  logic        spc_ok;
  logic        count_ok;
  logic        total_ok;
  logic [21:0] rds_full;

  assign jump_ok  = (jump_byte_i == JumpShort) || (jump_byte_i == JumpNear);
  assign bps_ok   = (sector_bytes_i != 16'd0) && (sector_bytes_i[8:0] == 9'd0);
  assign spc_ok   = (cluster_sectors_i != 8'd0) && !cluster_sectors_i[0];
  assign count_ok = (reserved_count_i != 16'd0) && (table_copies_i != 8'd0);
  assign total_ok = (total_small_i == 16'd0) != (total_large_i == 32'd0);

  // Root entries times 32 plus sector size minus one, later divided by the
  // sector size in units of 512 bytes.
  assign rds_full = {1'b0, root_entries_i, 5'd0} + {6'd0, sector_bytes_i} - 22'd1;

  always_comb begin
    job_o.valid     = jump_ok && bps_ok && spc_ok && count_ok && total_ok;
    job_o.sec_units = sector_bytes_i[15:9];
    job_o.rds_num   = rds_full[21:9];
    job_o.spc       = cluster_sectors_i;
    job_o.rsv       = reserved_count_i;
    job_o.copies    = table_copies_i;
    job_o.tsize     = (table_sectors_small_i != 16'd0) ? {16'd0, table_sectors_small_i}
                                                        : table_sectors_large_i;
    job_o.total     = (total_small_i != 16'd0) ? {16'd0, total_small_i} : total_large_i;
  end

endmodule

[rtl/fvhc_queue.sv]
`timescale 1ns / 1ps

module fvhc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fvhc_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fvhc_pkg::job_t data_o
);
  import fvhc_pkg::*;

  localparam int Depth = 2;

  job_t       mem_q [Depth];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(Depth));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/fvhc_back.sv]
`timescale 1ns / 1ps

module fvhc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  fvhc_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic [1:0]     fat_kind_o,
  output logic [12:0]    root_sectors_o,
  output logic [31:0]    cluster_total_o
);
  import fvhc_pkg::*;

  typedef enum logic [2:0] {SIdle, SRds, SMul, SSum, SClu, SOut} state_e;

  state_e      state_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  job_t        job_q;
  logic [31:0] quo_q;
  logic [7:0]  rem_q;
  logic [7:0]  div_q;
  logic [12:0] rds_q;
  logic [31:0] prod_q;
  logic [16:0] base_q;
  logic [1:0]  status_q;
  logic [1:0]  kind_q;
  logic [12:0] rds_out_q;
  logic [31:0] clu_out_q;

  logic [8:0]  t0;
  logic [8:0]  t1;
  logic        g0;
  logic        g1;
  logic [7:0]  r0;
  logic [7:0]  rem_d;
  logic [31:0] quo_d;
  logic        out_write;

  // Restoring divider, two quotient bits per cycle.
  always_comb begin
    t0    = {rem_q, quo_q[31]};
    g0    = (t0 >= {1'b0, div_q});
    r0    = g0 ? 8'(t0 - {1'b0, div_q}) : t0[7:0];
    t1    = {r0, quo_q[30]};
    g1    = (t1 >= {1'b0, div_q});
    rem_d = g1 ? 8'(t1 - {1'b0, div_q}) : t1[7:0];
    quo_d = {quo_q[29:0], g0, g1};
  end

  assign pop_o     = (state_q == SIdle) && !empty_i;
  assign out_write = (state_q == SOut) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (!empty_i) begin
            cnt_q   <= 4'd6;
            state_q <= job_i.valid ? SRds : SOut;
          end
        end
        SRds: begin
          if (cnt_q == 4'd0) begin
            state_q <= SMul;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        SMul: begin
          state_q <= SSum;
        end
        SSum: begin
          cnt_q   <= 4'd15;
          state_q <= SClu;
        end
        SClu: begin
          if (cnt_q == 4'd0) begin
            state_q <= SOut;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        SOut: begin
          if (out_write) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (!empty_i) begin
          job_q <= job_i;
          rem_q <= 8'd0;
          div_q <= {1'b0, job_i.sec_units};
          quo_q <= {1'b0, job_i.rds_num, 18'd0};
        end
      end
      SRds, SClu: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      SMul: begin
        rds_q  <= quo_q[12:0];
        prod_q <= 32'(job_q.copies * job_q.tsize);
        base_q <= {1'b0, job_q.rsv} + {4'd0, quo_q[12:0]};
      end
      SSum: begin
        quo_q <= job_q.total - prod_q - {15'd0, base_q};
        rem_q <= 8'd0;
        div_q <= job_q.spc;
      end
      SOut: begin
        if (out_write) begin
          if (!job_q.valid) begin
            status_q  <= StInvalid;
            kind_q    <= KindUnknown;
            rds_out_q <= 13'd0;
            clu_out_q <= 32'd0;
          end else begin
            rds_out_q <= rds_q;
            clu_out_q <= quo_q;
            if (quo_q < SmallLimit) begin
              status_q <= StFat12;
              kind_q   <= KindUnknown;
            end else if (quo_q < MediumLimit) begin
              status_q <= StOk;
              kind_q   <= KindFat16;
            end else begin
              status_q <= StOk;
              kind_q   <= KindFat32;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign fat_kind_o      = kind_q;
  assign root_sectors_o  = rds_out_q;
  assign cluster_total_o = clu_out_q;

endmodule

[rtl/fat_volume_header_classifier_top.sv]
`timescale 1ns / 1ps

// Validates the decoded boot-sector fields of a FAT volume and returns one
// result per header: status, FAT kind, root-directory sectors and data cluster
// count. In the back end a header that passes validation goes through the
// shared divider, which retires two quotient bits per cycle, first for the
// root-directory size and then for the cluster count, with the idle, multiply,
// sum and output states around it; an invalid header goes from idle straight
// to output. A two-entry queue sits between the classifying front end and the
// back end, so new headers are taken while earlier ones are computed and while
// a finished result waits in the output register.
module fat_volume_header_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  jump_byte_i,
  input  logic [15:0] sector_bytes_i,
  input  logic [7:0]  cluster_sectors_i,
  input  logic [15:0] reserved_count_i,
  input  logic [7:0]  table_copies_i,
  input  logic [15:0] root_entries_i,
  input  logic [15:0] total_small_i,
  input  logic [15:0] table_sectors_small_i,
  input  logic [31:0] total_large_i,
  input  logic [31:0] table_sectors_large_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  fat_kind_o,
  output logic [12:0] root_sectors_o,
  output logic [31:0] cluster_total_o
);
  import fvhc_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic queue_full;
  logic queue_empty;
  logic queue_push;
  logic queue_pop;

  assign in_ready_o = !queue_full;
  assign queue_push = in_valid_i && !queue_full;

  fvhc_front u_front (
    .jump_byte_i           (jump_byte_i),
    .sector_bytes_i        (sector_bytes_i),
    .cluster_sectors_i     (cluster_sectors_i),
    .reserved_count_i      (reserved_count_i),
    .table_copies_i        (table_copies_i),
    .root_entries_i        (root_entries_i),
    .total_small_i         (total_small_i),
    .table_sectors_small_i (table_sectors_small_i),
    .total_large_i         (total_large_i),
    .table_sectors_large_i (table_sectors_large_i),
    .job_o                 (front_job)
  );

  fvhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .data_i  (front_job),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .data_o  (queue_job)
  );

  fvhc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (queue_empty),
    .job_i           (queue_job),
    .pop_o           (queue_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .fat_kind_o      (fat_kind_o),
    .root_sectors_o  (root_sectors_o),
    .cluster_total_o (cluster_total_o)
  );

endmodule

[rtl/fvhc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fvhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [1:0]  fat_kind_o,
  input logic [12:0] root_sectors_o,
  input logic [31:0] cluster_total_o
);
  import fvhc_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(cluster_total_o) && $stable(root_sectors_o))

  `ASSERT_IMPLY(a_invalid_zero, clk_i, rst_ni, out_valid_o && (status_o == StInvalid),
    (fat_kind_o == KindUnknown) && (root_sectors_o == 13'd0) && (cluster_total_o == 32'd0))

  `ASSERT_IMPLY(a_fat12_range, clk_i, rst_ni, out_valid_o && (status_o == StFat12),
    (fat_kind_o == KindUnknown) && (cluster_total_o < SmallLimit))

  `ASSERT_IMPLY(a_ok_kind, clk_i, rst_ni, out_valid_o && (status_o == StOk),
    ((fat_kind_o == KindFat16) && (cluster_total_o >= SmallLimit) && (cluster_total_o < MediumLimit)) || ((fat_kind_o == KindFat32) && (cluster_total_o >= MediumLimit)))

endmodule

bind fat_volume_header_classifier_top fvhc_checker u_fvhc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .fat_kind_o      (fat_kind_o),
  .root_sectors_o  (root_sectors_o),
  .cluster_total_o (cluster_total_o)
);
